[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge outside reset
`define MAS_ASSERT(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// antecedent at one edge implies consequent at the next
`define MAS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/mas_pkg.sv]
// ----------------------------------------------------------------------------
// mas_pkg
// shared constants and types of the moving average block
// ----------------------------------------------------------------------------
package mas_pkg;

    localparam int WINDOW_MAX  = 256;
    localparam int PRICE_BITS  = 32;
    localparam int TAG_BITS    = 32;
    localparam int RING_AW     = $clog2(WINDOW_MAX);
    localparam int LEN_BITS    = $clog2(WINDOW_MAX) + 1;
    localparam int SUM_BITS    = PRICE_BITS + RING_AW;
    localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = LEN_BITS;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_LENGTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SELECT = 2'd2;

    // average modes
    localparam logic MODE_SMA = 1'b0;
    localparam logic MODE_EMA = 1'b1;

    // price selector codes
    localparam logic [1:0] SEL_CLOSE = 2'd0;
    localparam logic [1:0] SEL_OPEN  = 2'd1;
    localparam logic [1:0] SEL_HIGH  = 2'd2;
    localparam logic [1:0] SEL_LOW   = 2'd3;

    localparam logic [LEN_BITS-1:0] LENGTH_RESET = LEN_BITS'(20);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } mas_state_t;

    typedef struct packed {
        logic ready;       // input channel may take an item
        logic capture;     // item accepted, latch price and issue ring read
        logic accumulate;  // update ring, sum and counters
        logic div_start;   // launch the divider
        logic finish;      // load the output register
    } mas_cmd_t;

    typedef struct packed {
        logic warm_next;   // item leaves the block still warming up
        logic div_busy;
        logic out_free;    // output register can take a result
    } mas_stat_t;

endpackage

[hdl/mas_bar_if.sv]
// ----------------------------------------------------------------------------
// mas_bar_if / mas_avg_if
// valid/ready channels for bar items and average items
// ----------------------------------------------------------------------------
interface mas_bar_if;
    logic                           valid;
    logic                           ready;
    logic [mas_pkg::PRICE_BITS-1:0] close_price;
    logic [mas_pkg::PRICE_BITS-1:0] open_price;
    logic [mas_pkg::PRICE_BITS-1:0] high_price;
    logic [mas_pkg::PRICE_BITS-1:0] low_price;
    logic [mas_pkg::TAG_BITS-1:0]   bar_tag;

    modport source (output valid, close_price, open_price, high_price, low_price, bar_tag,
                    input ready);
    modport sink   (input valid, close_price, open_price, high_price, low_price, bar_tag,
                    output ready);
endinterface

interface mas_avg_if;
    logic                           valid;
    logic                           ready;
    logic [mas_pkg::PRICE_BITS-1:0] average_value;
    logic                           average_valid;
    logic [mas_pkg::TAG_BITS-1:0]   result_tag;

    modport source (output valid, average_value, average_valid, result_tag, input ready);
    modport sink   (input valid, average_value, average_valid, result_tag, output ready);
endinterface

[hdl/mas_div.sv]
// ----------------------------------------------------------------------------
// mas_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mas_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [mas_pkg::SUM_BITS-1:0]     dividend,
    input  logic [mas_pkg::LEN_BITS-1:0]     divisor,
    output logic                             busy,
    output logic [mas_pkg::SUM_BITS-1:0]     quotient
);

    logic [mas_pkg::DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [mas_pkg::SUM_BITS-1:0]     dvd_reg, dvd_next;
    logic [mas_pkg::LEN_BITS-1:0]     rem_reg, rem_next;
    logic [mas_pkg::LEN_BITS-1:0]     dsr_reg, dsr_next;
    logic [mas_pkg::LEN_BITS:0]       rem_shift;
    logic                             fits;

    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[mas_pkg::SUM_BITS-1]};
        fits      = rem_shift >= {1'b0, dsr_reg};
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            cnt_next = mas_pkg::DIV_CNT_BITS'(mas_pkg::SUM_BITS);
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            // quotient bits shift in where the dividend bits leave
            dvd_next = {dvd_reg[mas_pkg::SUM_BITS-2:0], fits};
            rem_next = fits ? mas_pkg::LEN_BITS'(rem_shift - {1'b0, dsr_reg})
                            : mas_pkg::LEN_BITS'(rem_shift);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = cnt_reg != '0;
    assign quotient = dvd_reg;

endmodule

[hdl/mas_datapath.sv]
// ----------------------------------------------------------------------------
// mas_datapath
// configuration, price ring, running sum, divider and output register
// ----------------------------------------------------------------------------
module mas_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mas_pkg::mas_cmd_t                   cmd,
    output mas_pkg::mas_stat_t                  stat,
    input  logic                                cfg_we,
    input  logic [mas_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [mas_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic [mas_pkg::PRICE_BITS-1:0]      close_price,
    input  logic [mas_pkg::PRICE_BITS-1:0]      open_price,
    input  logic [mas_pkg::PRICE_BITS-1:0]      high_price,
    input  logic [mas_pkg::PRICE_BITS-1:0]      low_price,
    input  logic [mas_pkg::TAG_BITS-1:0]        bar_tag,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [mas_pkg::PRICE_BITS-1:0]      average_value,
    output logic                                average_valid,
    output logic [mas_pkg::TAG_BITS-1:0]        result_tag
);

    // configuration
    logic [mas_pkg::LEN_BITS-1:0]   length_reg;
    logic                           mode_reg;
    logic [1:0]                     select_reg;
    logic                           clear_run;

    // run state
    logic [mas_pkg::RING_AW-1:0]    ptr_reg;
    logic [mas_pkg::SUM_BITS-1:0]   sum_reg, sum_next;
    logic [mas_pkg::LEN_BITS-1:0]   bars_reg, bars_next;
    logic [mas_pkg::PRICE_BITS-1:0] last_reg;

    // per item
    logic [mas_pkg::PRICE_BITS-1:0] price_reg, price_sel;
    logic [mas_pkg::TAG_BITS-1:0]   tag_reg;
    logic [mas_pkg::PRICE_BITS-1:0] leave_reg;
    logic                           res_valid_reg;
    logic                           use_ema_reg;
    logic                           below_reg;

    // output register
    logic                           out_valid_reg;
    logic [mas_pkg::PRICE_BITS-1:0] out_value_reg;
    logic                           out_flag_reg;
    logic [mas_pkg::TAG_BITS-1:0]   out_tag_reg;

    logic [mas_pkg::PRICE_BITS-1:0] ring_mem [mas_pkg::WINDOW_MAX];

    logic [mas_pkg::LEN_BITS-1:0]   act_len;
    logic [mas_pkg::RING_AW-1:0]    leave_idx;
    logic                           full;
    logic                           use_ema;
    logic                           below;
    logic [mas_pkg::PRICE_BITS-1:0] diff;
    logic [mas_pkg::SUM_BITS-1:0]   div_dividend;
    logic [mas_pkg::LEN_BITS-1:0]   div_divisor;
    logic [mas_pkg::SUM_BITS-1:0]   quotient;
    logic [mas_pkg::PRICE_BITS-1:0] q_low;
    logic [mas_pkg::PRICE_BITS-1:0] avg;
    logic                           div_busy;

    // zero acts as one, anything above the ring depth as the depth
    always_comb
    begin
        if (length_reg == '0)
            act_len = mas_pkg::LEN_BITS'(1);
        else if (length_reg > mas_pkg::LEN_BITS'(mas_pkg::WINDOW_MAX))
            act_len = mas_pkg::LEN_BITS'(mas_pkg::WINDOW_MAX);
        else
            act_len = length_reg;
    end

    assign clear_run = cfg_we && (cfg_index == mas_pkg::REG_LENGTH ||
                                  cfg_index == mas_pkg::REG_MODE ||
                                  cfg_index == mas_pkg::REG_SELECT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= mas_pkg::LENGTH_RESET;
            mode_reg   <= mas_pkg::MODE_SMA;
            select_reg <= mas_pkg::SEL_CLOSE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mas_pkg::REG_LENGTH: length_reg <= cfg_data;
                mas_pkg::REG_MODE:   mode_reg   <= cfg_data[0];
                mas_pkg::REG_SELECT: select_reg <= cfg_data[1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (select_reg)
            mas_pkg::SEL_CLOSE: price_sel = close_price;
            mas_pkg::SEL_OPEN:  price_sel = open_price;
            mas_pkg::SEL_HIGH:  price_sel = high_price;
            default:            price_sel = low_price;
        endcase
    end

    // entry that drops out of the window, length bars back
    assign leave_idx = ptr_reg - act_len[mas_pkg::RING_AW-1:0];
    assign full      = bars_reg >= act_len;

    always_comb
    begin
        sum_next  = sum_reg + mas_pkg::SUM_BITS'(price_reg)
                  - (full ? mas_pkg::SUM_BITS'(leave_reg) : '0);
        bars_next = full ? bars_reg : bars_reg + 1'b1;
        use_ema   = (mode_reg == mas_pkg::MODE_EMA) && full;
        below     = price_reg < last_reg;
        diff      = below ? last_reg - price_reg : price_reg - last_reg;
        if (use_ema)
        begin
            div_dividend = mas_pkg::SUM_BITS'({diff, 1'b0});
            div_divisor  = act_len + 1'b1;
        end
        else
        begin
            div_dividend = sum_next;
            div_divisor  = act_len;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            price_reg <= price_sel;
            tag_reg   <= bar_tag;
            leave_reg <= ring_mem[leave_idx];
        end
        if (cmd.accumulate)
            ring_mem[ptr_reg] <= price_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accumulate)
        begin
            res_valid_reg <= bars_next >= act_len;
            use_ema_reg   <= use_ema;
            below_reg     <= below;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            sum_reg  <= '0;
            bars_reg <= '0;
            last_reg <= '0;
        end
        else if (clear_run)
        begin
            ptr_reg  <= '0;
            sum_reg  <= '0;
            bars_reg <= '0;
            last_reg <= '0;
        end
        else
        begin
            if (cmd.accumulate)
            begin
                ptr_reg  <= ptr_reg + 1'b1;
                sum_reg  <= sum_next;
                bars_reg <= bars_next;
            end
            if (cmd.finish && res_valid_reg)
                last_reg <= avg;
        end
    end

    mas_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // the step never passes the new price, so it stays in range
    always_comb
    begin
        q_low = quotient[mas_pkg::PRICE_BITS-1:0];
        if (!res_valid_reg)
            avg = '0;
        else if (!use_ema_reg)
            avg = q_low;
        else if (below_reg)
            avg = last_reg - q_low;
        else
            avg = last_reg + q_low;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_value_reg <= avg;
            out_flag_reg  <= res_valid_reg;
            out_tag_reg   <= tag_reg;
        end
    end

    assign stat.warm_next = bars_next < act_len;
    assign stat.div_busy  = div_busy;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign average_value = out_value_reg;
    assign average_valid = out_flag_reg;
    assign result_tag    = out_tag_reg;

endmodule

[hdl/mas_ctrl.sv]
// ----------------------------------------------------------------------------
// mas_ctrl
// sequencer for one bar: ring read, sum update, divide (skipped during warm-up), result load
// ----------------------------------------------------------------------------
module mas_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  mas_pkg::mas_stat_t  stat,
    output mas_pkg::mas_cmd_t   cmd
);

    mas_pkg::mas_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mas_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            mas_pkg::ST_IDLE:
            begin
                cmd.ready   = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = mas_pkg::ST_READ;
            end
            // ring read data lands here
            mas_pkg::ST_READ:
                state_next = mas_pkg::ST_SUM;
            mas_pkg::ST_SUM:
            begin
                cmd.accumulate = 1'b1;
                if (stat.warm_next)
                    state_next = mas_pkg::ST_DONE;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = mas_pkg::ST_DIV;
                end
            end
            mas_pkg::ST_DIV:
                if (!stat.div_busy)
                    state_next = mas_pkg::ST_DONE;
            mas_pkg::ST_DONE:
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = mas_pkg::ST_IDLE;
                end
            default:
                state_next = mas_pkg::ST_IDLE;
        endcase
    end

endmodule

[hdl/moving_average_sma_ema.sv]
// ----------------------------------------------------------------------------
// moving_average_sma_ema
// simple or exponential moving average of one selected price per bar
// ----------------------------------------------------------------------------
// One bar at a time: a bar that needs a division goes from acceptance
// through capture, ring read, sum update, the bit-serial divider and
// result load before the next bar is taken; warm-up bars skip the
// divider. The divider makes one quotient bit per cycle over the 40-bit
// running sum. The next bar is taken while a result still waits in the
// output register. A write to the length, mode or select register restarts
// the warm-up; the ring needs no clearing pass.
`include "assert_macros.svh"

module moving_average_sma_ema (
    input  logic                               clk,
    input  logic                               rst_n,
    mas_bar_if.sink                            in_ch,
    mas_avg_if.source                          out_ch,
    input  logic                               cfg_we,
    input  logic [mas_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [mas_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    mas_pkg::mas_cmd_t  cmd;
    mas_pkg::mas_stat_t stat;

    mas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .stat     (stat),
        .cmd      (cmd)
    );

    mas_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .close_price   (in_ch.close_price),
        .open_price    (in_ch.open_price),
        .high_price    (in_ch.high_price),
        .low_price     (in_ch.low_price),
        .bar_tag       (in_ch.bar_tag),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .average_value (out_ch.average_value),
        .average_valid (out_ch.average_valid),
        .result_tag    (out_ch.result_tag)
    );

    assign in_ch.ready = cmd.ready;

    `MAS_ASSERT_NEXT(a_one_item_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready)
    `MAS_ASSERT(a_warmup_value_zero,
        !(out_ch.valid && !out_ch.average_valid) || out_ch.average_value == '0)
    `MAS_ASSERT(a_div_not_restarted, !(cmd.div_start && stat.div_busy))
    `MAS_ASSERT(a_finish_needs_slot, !cmd.finish || stat.out_free)

endmodule

[test/moving_average_sma_ema_tb.sv]
// ----------------------------------------------------------------------------
// moving_average_sma_ema_tb
// self-checking bench for the moving average block: a directed table of bars
// and register writes, then random phases over window lengths, modes and
// price selectors, with stalls on both channels. Typed table rows are checked
// against the table, others with an in-bench predictor of window sum and ema.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module moving_average_sma_ema_tb;
    import mas_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 50;
    localparam int RANDOM_PHASES  = 22;
    localparam int DIR_ROWS       = 29;
    localparam int REPORT_MAX     = 10;
    localparam logic [PRICE_BITS-1:0]   MAXP       = '1;
    // only index with no register behind it
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

    typedef enum logic { ROW_BAR, ROW_CFG } row_kind_t;

    typedef struct packed {
        logic [PRICE_BITS-1:0] close_p;
        logic [PRICE_BITS-1:0] open_p;
        logic [PRICE_BITS-1:0] high_p;
        logic [PRICE_BITS-1:0] low_p;
        logic [TAG_BITS-1:0]   tag;
    } bar_item_t;

    typedef struct packed {
        logic [PRICE_BITS-1:0] value;
        logic                  valid;
        logic [TAG_BITS-1:0]   tag;
    } avg_item_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] data;
        logic [PRICE_BITS-1:0]    close_p;
        logic [PRICE_BITS-1:0]    open_p;
        logic [PRICE_BITS-1:0]    high_p;
        logic [PRICE_BITS-1:0]    low_p;
        logic [TAG_BITS-1:0]      tag;
        logic                     typed;
        logic [PRICE_BITS-1:0]    exp_value;
        logic                     exp_valid;
    } dir_row_t;

    // bar rows carry REG_UNUSED in the index column, it is not used there
    dir_row_t dir_rows [DIR_ROWS] = '{
        // warm-up straight after reset: length 20, simple, close
        '{ROW_BAR, REG_UNUSED, 0, 0, MAXP, MAXP, MAXP, 0, 1, 0, 0},
        '{ROW_CFG, REG_LENGTH, 1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_BAR, REG_UNUSED, 0, MAXP, 0, 0, 0, MAXP, 1, MAXP, 1},
        '{ROW_BAR, REG_UNUSED, 0, 0, MAXP, MAXP, MAXP, 1, 1, 0, 1},
        // zero length behaves as one
        '{ROW_CFG, REG_LENGTH, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_BAR, REG_UNUSED, 0, 32'h1234_5678, 0, 0, 0, 2, 1, 32'h1234_5678, 1},
        '{ROW_CFG, REG_SELECT, SEL_OPEN, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_BAR, REG_UNUSED, 0, 0, MAXP, 0, 0, 3, 1, MAXP, 1},
        '{ROW_CFG, REG_SELECT, SEL_HIGH, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_BAR, REG_UNUSED, 0, 1, 1, 32'h8000_0001, 1, 4, 1, 32'h8000_0001, 1},
        '{ROW_CFG, REG_SELECT, SEL_LOW, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_BAR, REG_UNUSED, 0, MAXP, MAXP, MAXP, 32'h0000_FFFF, 5, 1, 32'h0000_FFFF, 1},
        // ema over two bars, seeded by the first simple average
        '{ROW_CFG, REG_LENGTH, 2, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, REG_MODE, MODE_EMA, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, REG_SELECT, SEL_CLOSE, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_BAR, REG_UNUSED, 0, MAXP, 0, 0, 0, 6, 1, 0, 0},
        '{ROW_BAR, REG_UNUSED, 0, MAXP, 0, 0, 0, 7, 1, MAXP, 1},
        // falling step, truncated toward zero
        '{ROW_BAR, REG_UNUSED, 0, 0, MAXP, MAXP, MAXP, 8, 1, 32'h5555_5555, 1},
        '{ROW_BAR, REG_UNUSED, 0, MAXP, 0, 0, 0, 9, 0, 0, 0},
        '{ROW_BAR, REG_UNUSED, 0, 7, 0, 0, 0, 10, 0, 0, 0},
        // length above the ring size is clipped to it
        '{ROW_CFG, REG_LENGTH, 300, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_BAR, REG_UNUSED, 0, 5, 0, 0, 0, 11, 1, 0, 0},
        '{ROW_CFG, REG_MODE, MODE_SMA, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, REG_LENGTH, 3, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_BAR, REG_UNUSED, 0, 10, 0, 0, 0, 12, 1, 0, 0},
        '{ROW_BAR, REG_UNUSED, 0, 20, 0, 0, 0, 13, 1, 0, 0},
        '{ROW_BAR, REG_UNUSED, 0, 31, 0, 0, 0, 14, 1, 20, 1},
        // write to an index with no register must not restart the window
        '{ROW_CFG, REG_UNUSED, 9'h1FF, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_BAR, REG_UNUSED, 0, 40, 0, 0, 0, 15, 0, 0, 0}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    mas_bar_if bar_ch ();
    mas_avg_if avg_ch ();

    moving_average_sma_ema i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (bar_ch),
        .out_ch    (avg_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state and settings
    logic [PRICE_BITS-1:0] ring_prices [WINDOW_MAX];
    logic [RING_AW-1:0]    ring_wr      = '0;
    logic [SUM_BITS-1:0]   price_total  = '0;
    logic [LEN_BITS-1:0]   bars_filled  = '0;
    logic [PRICE_BITS-1:0] prev_average = '0;
    logic [LEN_BITS-1:0]   set_length   = LENGTH_RESET;
    logic                  set_mode     = MODE_SMA;
    logic [1:0]            set_select   = SEL_CLOSE;

    avg_item_t             pending_averages [$];
    int                    mismatch_count = 0;
    int                    rx_stall_left  = 0;
    logic [31:0]           quiet_cycles   = '0;
    logic [PRICE_BITS-1:0] walk_level;
    bit                    tx_idle_on;
    bit                    rx_idle_on;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic avg_item_t predict_average(bar_item_t b);
        int unsigned           len;
        logic [PRICE_BITS-1:0] price;
        logic [PRICE_BITS-1:0] leaving;
        logic [LEN_BITS-1:0]   prior;
        logic [63:0]           avg;
        avg_item_t             r;
        len = (set_length == 0) ? 1 : ((set_length > WINDOW_MAX) ? WINDOW_MAX : set_length);
        case (set_select)
            SEL_CLOSE: price = b.close_p;
            SEL_OPEN:  price = b.open_p;
            SEL_HIGH:  price = b.high_p;
            default:   price = b.low_p;
        endcase
        prior   = bars_filled;
        leaving = '0;
        if (bars_filled >= len)
            leaving = ring_prices[RING_AW'((ring_wr + WINDOW_MAX - len) % WINDOW_MAX)];
        ring_prices[ring_wr] = price;
        ring_wr              = ring_wr + 1'b1;
        price_total          = price_total + price - leaving;
        if (bars_filled < len)
            bars_filled = bars_filled + 1'b1;
        r.tag = b.tag;
        if (bars_filled < len)
        begin
            r.value = '0;
            r.valid = 1'b0;
            return r;
        end
        // first full window seeds the ema with the plain average
        if (set_mode == MODE_SMA || prior < len)
            avg = price_total / len;
        else if (price >= prev_average)
            avg = prev_average + (64'd2 * (price - prev_average)) / (len + 1);
        else
            avg = prev_average - (64'd2 * (prev_average - price)) / (len + 1);
        prev_average = avg[PRICE_BITS-1:0];
        r.value      = avg[PRICE_BITS-1:0];
        r.valid      = 1'b1;
        return r;
    endfunction

    function automatic bar_item_t make_bar(int style);
        logic [PRICE_BITS-1:0] p [4];
        walk_level = walk_level + PRICE_BITS'($urandom_range(0, 4096)) - PRICE_BITS'(2048);
        for (int j = 0; j < 4; j++)
        begin
            case (style)
                1: p[j] = walk_level + PRICE_BITS'($urandom_range(0, 1023));
                2: p[j] = MAXP - PRICE_BITS'($urandom_range(0, 65535));
                default:
                begin
                    case ($urandom_range(0, 9))
                        0:       p[j] = '0;
                        1:       p[j] = MAXP;
                        2:       p[j] = PRICE_BITS'($urandom_range(0, 255));
                        3:       p[j] = MAXP - PRICE_BITS'($urandom_range(0, 255));
                        default: p[j] = $urandom;
                    endcase
                end
            endcase
        end
        return '{p[0], p[1], p[2], p[3], $urandom};
    endfunction

    task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_LENGTH: set_length = data;
            REG_MODE:   set_mode   = data[0];
            REG_SELECT: set_select = data[1:0];
            default:    ;
        endcase
        // any real register write starts a fresh warm-up
        if (idx != REG_UNUSED)
        begin
            ring_wr      = '0;
            price_total  = '0;
            bars_filled  = '0;
            prev_average = '0;
        end
    endtask

    // hold the sender until every average is back and the block is quiet
    task automatic settle();
        bar_ch.valid <= 1'b0;
        while (pending_averages.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_bar(bar_item_t b, bit typed, avg_item_t typed_res);
        avg_item_t r;
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            bar_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        bar_ch.valid       <= 1'b1;
        bar_ch.close_price <= b.close_p;
        bar_ch.open_price  <= b.open_p;
        bar_ch.high_price  <= b.high_p;
        bar_ch.low_price   <= b.low_p;
        bar_ch.bar_tag     <= b.tag;
        do
            @(posedge clk);
        while (!bar_ch.ready);
        r = predict_average(b);
        pending_averages.push_back(typed ? typed_res : r);
    endtask

    // result side: check each item, then decide on ready for the next edge
    always @(posedge clk)
    begin
        avg_item_t got;
        avg_item_t want;
        if (rst_n)
        begin
            if (avg_ch.valid && avg_ch.ready)
            begin
                got = '{avg_ch.average_value, avg_ch.average_valid, avg_ch.result_tag};
                if (pending_averages.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected average: value %h valid %b tag %h",
                                 got.value, got.valid, got.tag);
                end
                else
                begin
                    want = pending_averages.pop_front();
                    if (got.value !== want.value || got.valid !== want.valid ||
                        got.tag !== want.tag)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("average mismatch: expected %h/%b/%h, got %h/%b/%h",
                                     want.value, want.valid, want.tag,
                                     got.value, got.valid, got.tag);
                    end
                end
            end
            if (rx_stall_left > 0)
            begin
                avg_ch.ready <= 1'b0;
                rx_stall_left--;
            end
            else if (rx_idle_on && $urandom_range(0, 9) == 0)
            begin
                rx_stall_left = $urandom_range(1, 14) - 1;
                avg_ch.ready <= 1'b0;
            end
            else
                avg_ch.ready <= 1'b1;
        end
        else
            avg_ch.ready <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((bar_ch.valid && bar_ch.ready) || (avg_ch.valid && avg_ch.ready))
                quiet_cycles <= '0;
            else if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("moving_average_sma_ema regression: fail");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1'b1;
        end
    end

    initial
    begin
        bar_item_t               b;
        avg_item_t               want;
        logic [CFG_DATA_BITS-1:0] len_pick;
        logic                    mode_pick;
        logic [1:0]              sel_pick;
        int                      eff_len;
        int                      nbars;
        int                      style;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_LENGTH;
        cfg_data           = '0;
        bar_ch.valid       = 1'b0;
        bar_ch.close_price = '0;
        bar_ch.open_price  = '0;
        bar_ch.high_price  = '0;
        bar_ch.low_price   = '0;
        bar_ch.bar_tag     = '0;
        walk_level         = $urandom;
        tx_idle_on         = 1'b1;
        rx_idle_on         = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                settle();
                write_register(dir_rows[i].idx, dir_rows[i].data);
            end
            else
            begin
                b    = '{dir_rows[i].close_p, dir_rows[i].open_p, dir_rows[i].high_p,
                         dir_rows[i].low_p, dir_rows[i].tag};
                want = '{dir_rows[i].exp_value, dir_rows[i].exp_valid, dir_rows[i].tag};
                send_bar(b, dir_rows[i].typed, want);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            // last phases run with both sides flat out
            tx_idle_on = (p < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (p < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            mode_pick  = 1'($urandom_range(0, 1));
            sel_pick   = 2'($urandom_range(0, 3));
            style      = $urandom_range(0, 1);
            case (p)
                2:
                begin
                    // full ring of near-maximum prices drives the sum to its top
                    len_pick  = CFG_DATA_BITS'(WINDOW_MAX);
                    mode_pick = MODE_SMA;
                    style     = 2;
                end
                5:
                begin
                    len_pick  = '1;
                    mode_pick = MODE_EMA;
                end
                8:       len_pick = '0;
                default:
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: len_pick = CFG_DATA_BITS'($urandom_range(1, 8));
                        6, 7:             len_pick = CFG_DATA_BITS'(20);
                        8:                len_pick = CFG_DATA_BITS'($urandom_range(9, 64));
                        default:          len_pick = CFG_DATA_BITS'(1);
                    endcase
                end
            endcase
            eff_len = (len_pick == 0) ? 1 : ((len_pick > WINDOW_MAX) ? WINDOW_MAX : len_pick);
            nbars   = (eff_len <= 20) ? 60 : eff_len + 40;

            settle();
            write_register(REG_MODE, CFG_DATA_BITS'(mode_pick));
            write_register(REG_SELECT, CFG_DATA_BITS'(sel_pick));
            write_register(REG_LENGTH, len_pick);
            for (int k = 0; k < nbars; k++)
                send_bar(make_bar(style), 1'b0, '0);
        end

        settle();
        if (mismatch_count == 0 && pending_averages.size() == 0)
            $display("moving_average_sma_ema regression: pass");
        else
            $display("moving_average_sma_ema regression: fail");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/mas_pkg.sv
hdl/mas_bar_if.sv
hdl/mas_div.sv
hdl/mas_datapath.sv
hdl/mas_ctrl.sv
hdl/moving_average_sma_ema.sv
test/moving_average_sma_ema_tb.sv
